FILE: src/virtqueue_ring_engine_macros.svh
// Assertion macros shared by the virtqueue ring engine checkers.
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef VIRTQUEUE_RING_ENGINE_MACROS_SVH
`define VIRTQUEUE_RING_ENGINE_MACROS_SVH

// hold cons in the same cycle as ante
`define VRE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// hold cons in the cycle after ante
`define VRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/vre_pkg.sv
// Package for the virtqueue ring engine: command and result codes, FSM states.
// No dependencies.
package vre_pkg;

    localparam int IDX_W       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = 5;

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_KICK   = 1'b1;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_USED  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_EMPTY,
        S_RING,
        S_LEN,
        S_EMIT
    } state_t;

endpackage

FILE: src/vre_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies.
module vre_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/virtqueue_ring_engine.sv
// Top level of the split-virtqueue engine: control FSM, ring indices, result register.
// Depends on vre_pkg and vre_ram (descriptor length table and available ring).
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | cmd, desc_index, buffer_len
//  out     | output    | out_valid/out_ready| result_kind .. kick_count
//
// A submit is accepted, then the table and ring are written (unless the ring is full) with the acknowledgement.
// A kick passes S_RING, S_LEN and S_EMIT once per used element (up to 16); an empty kick goes through S_EMPTY.
// Each element waits on the ring read, then the dependent length-table read.
// rst_n clears indices, totals and the FSM; memory contents are undefined until written.
// A stalled output holds the FSM in S_SUB, S_EMPTY or S_EMIT; input is taken only when idle.
module virtqueue_ring_engine
    import vre_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [3:0]  desc_index,
    input  logic [31:0] buffer_len,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic        accepted,
    output logic [3:0]  used_id,
    output logic [31:0] used_len,
    output logic [3:0]  done_slot,
    output logic        last,
    output logic [63:0] total_bytes,
    output logic [63:0] kick_count
);

    localparam int SW = $clog2(RING_DEPTH);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] avail_idx_reg, consume_idx_reg, used_idx_reg;
    logic [SW-1:0]    avail_slot_reg, consume_slot_reg, done_slot_reg;
    logic [63:0]      byte_total_reg, kicks_reg;
    logic [CNT_W-1:0] todo_reg, cnt_reg;
    logic [3:0]       desc_reg;
    logic [31:0]      blen_reg;
    logic             out_valid_reg;

    logic [1:0]       kind_reg;
    logic             acc_reg, last_reg;
    logic [3:0]       id_reg, slot_out_reg;
    logic [31:0]      len_reg;
    logic [63:0]      total_out_reg, kicks_out_reg;

    logic [IDX_W-1:0] pending;
    logic             ring_full;
    logic [CNT_W-1:0] todo_calc;
    logic             out_free;
    logic             in_fire;
    logic             sub_fire, sub_ok, empty_fire, emit_fire, last_elem;
    logic [3:0]       ring_q;
    logic [31:0]      len_q;
    logic [63:0]      total_sum;
    logic [SW+3:0]    slot_ext;

    function automatic logic [SW-1:0] slot_step(input logic [SW-1:0] slot,
                                                input logic [IDX_W-1:0] idx);
        logic [SW-1:0] r;
        if (idx == {IDX_W{1'b1}} || slot == SW'(RING_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = slot + 1'b1;
        end
        return r;
    endfunction

    vre_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (4)
    ) u_avail_ring (
        .clk   (clk),
        .we    (sub_ok),
        .waddr (avail_slot_reg),
        .wdata (desc_reg),
        .raddr (consume_slot_reg),
        .rdata (ring_q)
    );

    vre_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (32)
    ) u_len_table (
        .clk   (clk),
        .we    (sub_ok),
        .waddr (desc_reg),
        .wdata (blen_reg),
        .raddr (ring_q),
        .rdata (len_q)
    );

    assign pending   = avail_idx_reg - consume_idx_reg;
    assign ring_full = pending >= IDX_W'(RING_DEPTH);
    assign todo_calc = (pending > IDX_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS)
                                                       : pending[CNT_W-1:0];
    assign out_free  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign last_elem = cnt_reg == (todo_reg - 1'b1);
    assign total_sum = byte_total_reg + {32'd0, len_q};
    assign slot_ext  = {4'd0, done_slot_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == CMD_SUBMIT)
                    begin
                        state_next = S_SUB;
                    end
                    else if (pending == '0)
                    begin
                        state_next = S_EMPTY;
                    end
                    else
                    begin
                        state_next = S_RING;
                    end
                end
            end
            S_SUB, S_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RING:
            begin
                state_next = S_LEN;
            end
            S_LEN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_elem ? S_IDLE : S_RING;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        sub_fire   = 1'b0;
        empty_fire = 1'b0;
        emit_fire  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_SUB:
            begin
                sub_fire = out_free;
            end
            S_EMPTY:
            begin
                empty_fire = out_free;
            end
            S_EMIT:
            begin
                emit_fire = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        sub_ok = sub_fire && !ring_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            avail_idx_reg    <= '0;
            consume_idx_reg  <= '0;
            used_idx_reg     <= '0;
            avail_slot_reg   <= '0;
            consume_slot_reg <= '0;
            done_slot_reg    <= '0;
            byte_total_reg   <= '0;
            kicks_reg        <= '0;
            todo_reg         <= '0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire && cmd == CMD_KICK)
            begin
                kicks_reg <= kicks_reg + 64'd1;
                todo_reg  <= todo_calc;
                cnt_reg   <= '0;
            end
            if (sub_ok)
            begin
                avail_idx_reg  <= avail_idx_reg + 1'b1;
                avail_slot_reg <= slot_step(avail_slot_reg, avail_idx_reg);
            end
            if (emit_fire)
            begin
                byte_total_reg   <= total_sum;
                consume_idx_reg  <= consume_idx_reg + 1'b1;
                consume_slot_reg <= slot_step(consume_slot_reg, consume_idx_reg);
                used_idx_reg     <= used_idx_reg + 1'b1;
                done_slot_reg    <= slot_step(done_slot_reg, used_idx_reg);
                cnt_reg          <= cnt_reg + 1'b1;
            end
            if (sub_fire || empty_fire || emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            desc_reg <= desc_index;
            blen_reg <= buffer_len;
        end
        if (sub_fire || empty_fire)
        begin
            kind_reg      <= sub_fire ? KIND_ACK : KIND_EMPTY;
            acc_reg       <= sub_ok;
            id_reg        <= '0;
            len_reg       <= '0;
            slot_out_reg  <= '0;
            last_reg      <= 1'b1;
            total_out_reg <= byte_total_reg;
            kicks_out_reg <= kicks_reg;
        end
        else if (emit_fire)
        begin
            kind_reg      <= KIND_USED;
            acc_reg       <= 1'b0;
            id_reg        <= ring_q;
            len_reg       <= len_q;
            slot_out_reg  <= slot_ext[3:0];
            last_reg      <= last_elem;
            total_out_reg <= total_sum;
            kicks_out_reg <= kicks_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign accepted    = acc_reg;
    assign used_id     = id_reg;
    assign used_len    = len_reg;
    assign done_slot   = slot_out_reg;
    assign last        = last_reg;
    assign total_bytes = total_out_reg;
    assign kick_count  = kicks_out_reg;

endmodule

FILE: src/vre_checker.sv
// Port-level checker for the virtqueue ring engine, bound to the top level.
// Depends on vre_pkg and virtqueue_ring_engine_macros.svh.
`include "virtqueue_ring_engine_macros.svh"

module vre_checker
    import vre_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_kind,
    input logic        accepted,
    input logic        last,
    input logic [63:0] total_bytes
);

    `VRE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(total_bytes), "output transaction dropped while stalled")
    `VRE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while a transaction is in progress")
    `VRE_ASSERT_SAME(a_single_last, out_valid && result_kind != KIND_USED, last, "acknowledge or empty kick without last")
    `VRE_ASSERT_SAME(a_used_not_ack, out_valid && result_kind != KIND_ACK, !accepted, "accepted set on a non-acknowledge result")

endmodule

bind virtqueue_ring_engine vre_checker u_vre_checker (.*);
